>>> hw/rtl/cnrc_pkg.sv
// ----------------------------------------------------------------------------
// cnrc_pkg
// shared types, constants and helpers of the nearest reference color classifier
// ----------------------------------------------------------------------------
package cnrc_pkg;

    // channel and field widths fixed by the item format
    localparam int SAMPLE_W     = 16;
    localparam int THR_W        = 16;
    localparam int RGB_W        = 48;
    localparam int CLASS_W      = 3;
    localparam int DIST_OUT_W   = 18;
    localparam int CFG_DATA_W   = 48;
    localparam int CFG_INDEX_W  = 3;
    localparam int NUM_CH       = 3;

    // presence compare runs on signed values one bit wider than baseline + threshold
    localparam int CMP_W        = THR_W + 2;

    // defaults handed to the top level parameters
    localparam int NUM_CLASSES_DEF  = 5;
    localparam int CHANNEL_BITS_DEF = 16;

    // reference storage is always present for every class register
    localparam int REG_SLOTS    = 5;
    localparam int SLOT_W       = $clog2(REG_SLOTS);

    // register reset values
    localparam logic [THR_W-1:0] THR_RESET      = THR_W'(25);
    localparam logic [RGB_W-1:0] BASELINE_RESET = {16'd106, 16'd79, 16'd68};
    localparam logic [RGB_W-1:0] REF_RESET      = '0;

    // largest class index the result can carry
    localparam logic [CLASS_W-1:0] CLASS_MAX = CLASS_W'(REG_SLOTS - 1);

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_THRESHOLD = 3'd0,
        CFG_BASELINE  = 3'd1,
        CFG_REF0      = 3'd2,
        CFG_REF1      = 3'd3,
        CFG_REF2      = 3'd4,
        CFG_REF3      = 3'd5,
        CFG_REF4      = 3'd6
    } cfg_index_t;

    // channel order inside a packed color
    typedef enum logic [1:0] {
        CH_RED   = 2'd0,
        CH_GREEN = 2'd1,
        CH_BLUE  = 2'd2
    } channel_t;

    // control that travels with each pipeline stage
    typedef struct packed {
        logic valid;
        logic present;
    } cnrc_stage_ctl_t;

    // one channel of a packed color, red in the top slice
    function automatic logic [SAMPLE_W-1:0] chan_of(input logic [RGB_W-1:0] packed_rgb,
                                                     input channel_t ch);
        logic [SAMPLE_W-1:0] res;
        begin
            case (ch)
                CH_RED:   res = packed_rgb[47:32];
                CH_GREEN: res = packed_rgb[31:16];
                CH_BLUE:  res = packed_rgb[15:0];
                default:  res = '0;
            endcase
            return res;
        end
    endfunction

endpackage

>>> hw/rtl/cnrc_if.sv
// ----------------------------------------------------------------------------
// cnrc_if
// valid/ready channels for sample items and result items
// ----------------------------------------------------------------------------
interface cnrc_sample_if;
    import cnrc_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample_red;
    logic [SAMPLE_W-1:0] sample_green;
    logic [SAMPLE_W-1:0] sample_blue;

    modport source (output valid, output sample_red, output sample_green,
                    output sample_blue, input ready);
    modport sink   (input valid, input sample_red, input sample_green,
                    input sample_blue, output ready);
endinterface

interface cnrc_result_if;
    import cnrc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  object_present;
    logic [CLASS_W-1:0]    best_class;
    logic [DIST_OUT_W-1:0] best_distance;

    modport source (output valid, output object_present, output best_class,
                    output best_distance, input ready);
    modport sink   (input valid, input object_present, input best_class,
                    input best_distance, output ready);
endinterface

>>> hw/rtl/cnrc_front.sv
// ----------------------------------------------------------------------------
// cnrc_front
// stage 1: presence test against the baseline and per-channel absolute differences
// ----------------------------------------------------------------------------
module cnrc_front #(
    parameter int NUM_CLASSES  = cnrc_pkg::NUM_CLASSES_DEF,
    parameter int CHANNEL_BITS = cnrc_pkg::CHANNEL_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  logic [cnrc_pkg::SAMPLE_W-1:0]          sample_red,
    input  logic [cnrc_pkg::SAMPLE_W-1:0]          sample_green,
    input  logic [cnrc_pkg::SAMPLE_W-1:0]          sample_blue,
    input  logic [cnrc_pkg::THR_W-1:0]             threshold,
    input  logic [cnrc_pkg::RGB_W-1:0]             baseline,
    input  logic [cnrc_pkg::RGB_W-1:0]             refs [cnrc_pkg::REG_SLOTS],
    output cnrc_pkg::cnrc_stage_ctl_t              ctl_reg,
    output logic [CHANNEL_BITS-1:0]                absd_reg [NUM_CLASSES][cnrc_pkg::NUM_CH]
);
    import cnrc_pkg::*;

    logic [CHANNEL_BITS-1:0] rd       [NUM_CH];
    logic [CHANNEL_BITS-1:0] absd_next [NUM_CLASSES][NUM_CH];
    logic                    present;
    logic signed [CMP_W-1:0] rd_s, hi_s, lo_s;
    logic [SAMPLE_W-1:0]     chan_full;
    logic [CHANNEL_BITS-1:0] ref_ch, base_ch;
    cnrc_stage_ctl_t         ctl_next;

    always_comb
    begin
        rd[0] = sample_red[CHANNEL_BITS-1:0];
        rd[1] = sample_green[CHANNEL_BITS-1:0];
        rd[2] = sample_blue[CHANNEL_BITS-1:0];

        // signed window baseline +/- threshold, low edge may go negative
        present = 1'b0;
        for (int c = 0; c < NUM_CH; c++)
        begin
            chan_full = chan_of(baseline, channel_t'(c));
            base_ch   = chan_full[CHANNEL_BITS-1:0];
            rd_s      = signed'(CMP_W'(rd[c]));
            hi_s      = signed'(CMP_W'(base_ch)) + signed'(CMP_W'(threshold));
            lo_s      = signed'(CMP_W'(base_ch)) - signed'(CMP_W'(threshold));
            if (rd_s > hi_s || rd_s < lo_s)
                present = 1'b1;
        end

        for (int k = 0; k < NUM_CLASSES; k++)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                chan_full = chan_of(refs[k], channel_t'(c));
                ref_ch    = chan_full[CHANNEL_BITS-1:0];
                absd_next[k][c] = (rd[c] >= ref_ch) ? rd[c] - ref_ch : ref_ch - rd[c];
            end
        end

        ctl_next.valid   = in_valid;
        ctl_next.present = present;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (en)
            ctl_reg <= ctl_next;
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
            absd_reg <= absd_next;
    end

endmodule

>>> hw/rtl/cnrc_dist.sv
// ----------------------------------------------------------------------------
// cnrc_dist
// stage 2: L1 distance per reference class
// ----------------------------------------------------------------------------
module cnrc_dist #(
    parameter int NUM_CLASSES  = cnrc_pkg::NUM_CLASSES_DEF,
    parameter int CHANNEL_BITS = cnrc_pkg::CHANNEL_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  cnrc_pkg::cnrc_stage_ctl_t ctl_in,
    input  logic [CHANNEL_BITS-1:0]   absd [NUM_CLASSES][cnrc_pkg::NUM_CH],
    output cnrc_pkg::cnrc_stage_ctl_t ctl_reg,
    output logic [CHANNEL_BITS+1:0]   dist_reg [NUM_CLASSES]
);
    import cnrc_pkg::*;

    localparam int DIST_W = CHANNEL_BITS + 2;

    logic [DIST_W-1:0] dist_next [NUM_CLASSES];

    always_comb
    begin
        for (int k = 0; k < NUM_CLASSES; k++)
            dist_next[k] = DIST_W'(absd[k][0]) + DIST_W'(absd[k][1]) + DIST_W'(absd[k][2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (en)
            ctl_reg <= ctl_in;
    end

    // only present items need their distances
    always_ff @(posedge clk)
    begin
        if (en && ctl_in.valid && ctl_in.present)
            dist_reg <= dist_next;
    end

endmodule

>>> hw/rtl/cnrc_min.sv
// ----------------------------------------------------------------------------
// cnrc_min
// stage 3: nearest class search and result register
// ----------------------------------------------------------------------------
module cnrc_min #(
    parameter int NUM_CLASSES  = cnrc_pkg::NUM_CLASSES_DEF,
    parameter int CHANNEL_BITS = cnrc_pkg::CHANNEL_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  cnrc_pkg::cnrc_stage_ctl_t         ctl_in,
    input  logic [CHANNEL_BITS+1:0]           l1_sum [NUM_CLASSES],
    output logic                              valid_reg,
    output logic                              present_reg,
    output logic [cnrc_pkg::CLASS_W-1:0]      class_reg,
    output logic [cnrc_pkg::DIST_OUT_W-1:0]   distance_reg
);
    import cnrc_pkg::*;

    localparam int DIST_W = CHANNEL_BITS + 2;

    logic [DIST_W-1:0]     best_d;
    logic [CLASS_W-1:0]    best_k;
    logic [CLASS_W-1:0]    class_next;
    logic [DIST_OUT_W-1:0] distance_next;

    // strict less-than keeps the lowest index on a tie
    always_comb
    begin
        best_d = l1_sum[0];
        best_k = '0;
        for (int k = 1; k < NUM_CLASSES; k++)
        begin
            if (l1_sum[k] < best_d)
            begin
                best_d = l1_sum[k];
                best_k = CLASS_W'(k);
            end
        end
        class_next    = ctl_in.present ? best_k : '0;
        distance_next = ctl_in.present ? DIST_OUT_W'(best_d) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= ctl_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en && ctl_in.valid)
        begin
            present_reg  <= ctl_in.present;
            class_reg    <= class_next;
            distance_reg <= distance_next;
        end
    end

endmodule

>>> hw/rtl/color_nearest_reference_classifier.sv
// ----------------------------------------------------------------------------
// color_nearest_reference_classifier
// flags an object when a color reading leaves the empty-slot window and names
// the nearest of the reference colors by L1 distance
// ----------------------------------------------------------------------------
// pipeline: three register stages (front, dist, min), the result registered in min
// throughput: one item per cycle unless the result side stalls, set by the three-stage register pipeline
// stalls back up stage by stage; an empty stage still takes an item
// reset: pipeline empty, threshold 25, baseline 106/79/68, references zero
// ----------------------------------------------------------------------------
module color_nearest_reference_classifier #(
    parameter int NUM_CLASSES  = cnrc_pkg::NUM_CLASSES_DEF,
    parameter int CHANNEL_BITS = cnrc_pkg::CHANNEL_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cnrc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [cnrc_pkg::CFG_DATA_W-1:0]   cfg_data,
    cnrc_sample_if.sink                       sample,
    cnrc_result_if.source                     result
);
    import cnrc_pkg::*;

    localparam int DIST_W = CHANNEL_BITS + 2;

    // configuration registers
    logic [THR_W-1:0] threshold_reg;
    logic [RGB_W-1:0] baseline_reg;
    logic [RGB_W-1:0] ref_reg [REG_SLOTS];

    // stage control and payload
    cnrc_stage_ctl_t         ctl1, ctl2;
    logic [CHANNEL_BITS-1:0] absd [NUM_CLASSES][NUM_CH];
    logic [DIST_W-1:0]       l1_sum [NUM_CLASSES];
    logic                    out_valid;

    // per-stage advance: a stage moves when it is empty or the next one moves
    logic en1, en2, en3;

    assign en3 = !out_valid || result.ready;
    assign en2 = !ctl2.valid || en3;
    assign en1 = !ctl1.valid || en2;

    assign sample.ready = en1;
    assign result.valid = out_valid;

    // register writes; indexes past the last reference are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THR_RESET;
            baseline_reg  <= BASELINE_RESET;
            for (int i = 0; i < REG_SLOTS; i++)
                ref_reg[i] <= REF_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_THRESHOLD: threshold_reg <= cfg_data[THR_W-1:0];
                CFG_BASELINE:  baseline_reg  <= cfg_data[RGB_W-1:0];
                CFG_REF0, CFG_REF1, CFG_REF2, CFG_REF3, CFG_REF4:
                    ref_reg[SLOT_W'(cfg_index - CFG_REF0)] <= cfg_data[RGB_W-1:0];
                default: ;
            endcase
        end
    end

    // stage 1: window test and channel differences
    cnrc_front #(
        .NUM_CLASSES  (NUM_CLASSES),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en1),
        .in_valid     (sample.valid),
        .sample_red   (sample.sample_red),
        .sample_green (sample.sample_green),
        .sample_blue  (sample.sample_blue),
        .threshold    (threshold_reg),
        .baseline     (baseline_reg),
        .refs         (ref_reg),
        .ctl_reg      (ctl1),
        .absd_reg     (absd)
    );

    // stage 2: distance sums
    cnrc_dist #(
        .NUM_CLASSES  (NUM_CLASSES),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en2),
        .ctl_in   (ctl1),
        .absd     (absd),
        .ctl_reg  (ctl2),
        .dist_reg (l1_sum)
    );

    // stage 3: nearest class, feeds the result channel directly
    cnrc_min #(
        .NUM_CLASSES  (NUM_CLASSES),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_min (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en3),
        .ctl_in       (ctl2),
        .l1_sum       (l1_sum),
        .valid_reg    (out_valid),
        .present_reg  (result.object_present),
        .class_reg    (result.best_class),
        .distance_reg (result.best_distance)
    );

endmodule

>>> hw/rtl/cnrc_checker.sv
// ----------------------------------------------------------------------------
// cnrc_checker
// port-level checks of the classifier, attached by bind
// ----------------------------------------------------------------------------
module cnrc_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic                              object_present,
    input logic [cnrc_pkg::CLASS_W-1:0]      best_class,
    input logic [cnrc_pkg::DIST_OUT_W-1:0]   best_distance
);
    import cnrc_pkg::*;

    // a stalled result holds its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(object_present)
            && $stable(best_class) && $stable(best_distance))
        else $error("result changed while stalled");

    // an absent object reports zero class and distance
    a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !object_present |-> best_class == '0 && best_distance == '0)
        else $error("absent object with nonzero class or distance");

    // class index stays within the reference set
    a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> best_class <= CLASS_MAX)
        else $error("class index out of range");

    // an empty output stage never blocks the input
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

endmodule

bind color_nearest_reference_classifier cnrc_checker u_cnrc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (sample.ready),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .object_present (result.object_present),
    .best_class     (result.best_class),
    .best_distance  (result.best_distance)
);

>>> bench/color_nearest_reference_classifier_tb.sv
// ----------------------------------------------------------------------------
// color_nearest_reference_classifier_tb
// self-checking bench: streams color readings through the classifier under a
// series of register settings, predicts presence, nearest class and L1
// distance for every accepted item and compares each result item in order
// ----------------------------------------------------------------------------
module color_nearest_reference_classifier_tb;
    import cnrc_pkg::*;

    // block configuration under test, kept equal to the defaults of the top level
    localparam int NUM_CLASSES  = NUM_CLASSES_DEF;
    localparam int CHANNEL_BITS = CHANNEL_BITS_DEF;
    localparam int CH_MASK      = (1 << CHANNEL_BITS) - 1;

    // pipeline depth from the header of the top level
    localparam int PIPE_LATENCY = 3;

    // run shape
    localparam int NUM_PHASES   = 9;
    localparam int RANDOM_ITEMS = 95;
    localparam int HOLD_CYCLES  = 64;
    localparam int TIMEOUT      = 2000000;

    // the one index the 3-bit register address can reach that holds no register
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE   = 3'd7;
    localparam int                     NUM_INDEXES = 1 << CFG_INDEX_W;

    // one predicted result item
    typedef struct packed {
        logic                  present;
        logic [CLASS_W-1:0]    cls;
        logic [DIST_OUT_W-1:0] distance;
    } verdict_t;

    // receiver stall patterns
    typedef enum int {
        FLOW_FREE,
        FLOW_COIN,
        FLOW_EVERY_THIRD,
        FLOW_SPARSE
    } flow_mode_t;

    // predictor with its own copy of the registers, plus the queue of verdicts
    // still waiting for their result item
    class verdict_board;
        logic [THR_W-1:0] threshold;
        logic [RGB_W-1:0] baseline;
        logic [RGB_W-1:0] refs [REG_SLOTS];
        verdict_t         pending [$];
        int               mismatches;

        function new();
            threshold  = THR_RESET;
            baseline   = BASELINE_RESET;
            foreach (refs[k])
                refs[k] = REF_RESET;
            mismatches = 0;
        endfunction

        // channel c of a packed color: red on top, blue at the bottom
        function int channel(logic [RGB_W-1:0] rgb, int c);
            logic [RGB_W-1:0] shifted;
            shifted = rgb >> (32 - 16 * c);
            return int'(shifted[15:0]) & CH_MASK;
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [RGB_W-1:0] data);
            case (idx)
                CFG_THRESHOLD: threshold = data[THR_W-1:0];
                CFG_BASELINE:  baseline = data;
                CFG_REF0, CFG_REF1, CFG_REF2, CFG_REF3, CFG_REF4:
                    refs[int'(idx) - int'(CFG_REF0)] = data;
                default: ;
            endcase
        endfunction

        function verdict_t classify(logic [SAMPLE_W-1:0] red, logic [SAMPLE_W-1:0] green,
                                    logic [SAMPLE_W-1:0] blue);
            int       rd [NUM_CH];
            int       base;
            int       thr;
            int       diff;
            int       d;
            int       best_d;
            int       best_k;
            bit       present;
            verdict_t v;
            rd[0]   = int'(red) & CH_MASK;
            rd[1]   = int'(green) & CH_MASK;
            rd[2]   = int'(blue) & CH_MASK;
            thr     = int'(threshold);
            present = 1'b0;
            // signed window, the low edge may drop below zero
            for (int c = 0; c < NUM_CH; c++)
            begin
                base = channel(baseline, c);
                if (rd[c] > base + thr || rd[c] < base - thr)
                    present = 1'b1;
            end
            best_d = 0;
            best_k = 0;
            if (present)
            begin
                for (int k = 0; k < NUM_CLASSES && k < REG_SLOTS; k++)
                begin
                    d = 0;
                    for (int c = 0; c < NUM_CH; c++)
                    begin
                        diff = rd[c] - channel(refs[k], c);
                        d += (diff < 0) ? -diff : diff;
                    end
                    // strict compare keeps the lowest index on a tie
                    if (k == 0 || d < best_d)
                    begin
                        best_d = d;
                        best_k = k;
                    end
                end
            end
            v.present  = present;
            v.cls      = present ? best_k[CLASS_W-1:0] : '0;
            v.distance = present ? best_d[DIST_OUT_W-1:0] : '0;
            return v;
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] red, logic [SAMPLE_W-1:0] green,
                                  logic [SAMPLE_W-1:0] blue);
            pending.push_back(classify(red, green, blue));
        endfunction

        function void check_result(logic present, logic [CLASS_W-1:0] cls,
                                   logic [DIST_OUT_W-1:0] distance);
            verdict_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t unexpected result item: present=%0d class=%0d distance=%0d",
                             $time, present, cls, distance);
                return;
            end
            want = pending.pop_front();
            if (present !== want.present || cls !== want.cls || distance !== want.distance)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t mismatch: expected present=%0d class=%0d distance=%0d,",
                              " got present=%0d class=%0d distance=%0d"},
                             $time, want.present, want.cls, want.distance,
                             present, cls, distance);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    // plain register write port
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    cnrc_sample_if smp ();
    cnrc_result_if res ();

    verdict_board board = new();

    // register values for the next phase, indexed by register address
    logic [CFG_DATA_W-1:0] next_regs [NUM_INDEXES];

    // sender burst bookkeeping
    int burst_left;

    // receiver hold-off: armed by the stimulus, counted down by the receiver
    bit squeeze_armed;
    int hold_left;

    color_nearest_reference_classifier #(
        .NUM_CLASSES  (NUM_CLASSES),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (smp),
        .result    (res)
    );

    always #5 clk = ~clk;

    // safety net against a hung handshake
    initial
    begin
        #(TIMEOUT);
        $display("simulation failed");
        $finish;
    end

    function automatic logic [CFG_DATA_W-1:0] rand48();
        return CFG_DATA_W'({$urandom(), $urandom()});
    endfunction

    // a channel value around center; one time in four it lands on the spread
    // edge or one value inside it, on either side of center
    function automatic logic [SAMPLE_W-1:0] near_value(int center, int spread);
        int offset;
        int v;
        if ($urandom_range(0, 3) == 0)
            offset = spread - int'($urandom_range(0, 1));
        else
            offset = int'($urandom_range(0, spread));
        v = $urandom_range(0, 1) ? center + offset : center - offset;
        if (v < 0)
            v = 0;
        if (v > CH_MASK)
            v = CH_MASK;
        return v[SAMPLE_W-1:0];
    endfunction

    // writes every register address, the spare one too, from next_regs
    task automatic program_registers();
        for (int i = 0; i < NUM_INDEXES; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_INDEX_W'(i);
            cfg_data  <= next_regs[i];
            @(posedge clk);
            board.set_register(CFG_INDEX_W'(i), next_regs[i]);
        end
        cfg_we <= 1'b0;
    endtask

    // offers one item and returns once it has been taken; a new burst may
    // start with a gap, valid stays high inside a burst
    task automatic offer(logic [SAMPLE_W-1:0] red, logic [SAMPLE_W-1:0] green,
                         logic [SAMPLE_W-1:0] blue);
        int gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 7) == 0)
                burst_left = $urandom_range(40, 120);
            else
                burst_left = $urandom_range(1, 16);
            // no gaps while the receiver is held off, so the pipeline backs up
            gap = (squeeze_armed || hold_left > 0) ? 0 : $urandom_range(0, 9);
            if (gap > 0)
            begin
                smp.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        smp.valid        <= 1'b1;
        smp.sample_red   <= red;
        smp.sample_green <= green;
        smp.sample_blue  <= blue;
        do
            @(posedge clk);
        while (!smp.ready);
        board.note_sample(red, green, blue);
    endtask

    // stops offering and waits until every verdict has been matched
    task automatic drain();
        smp.valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY) @(posedge clk);
    endtask

    // receiver: checks every accepted result item and stalls on its own pattern
    initial
    begin
        flow_mode_t mode;
        int         mode_left;
        int         rx_cycle;
        mode      = FLOW_FREE;
        mode_left = 0;
        rx_cycle  = 0;
        hold_left = 0;
        res.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rx_cycle++;
            if (rst_n && res.valid && res.ready)
                board.check_result(res.object_present, res.best_class, res.best_distance);
            if (hold_left > 0)
            begin
                hold_left--;
                res.ready <= 1'b0;
            end
            else if (squeeze_armed)
            begin
                // long hold-off so the block fills up and stalls its input
                squeeze_armed = 1'b0;
                hold_left     = HOLD_CYCLES - 1;
                res.ready    <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = flow_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (mode)
                    FLOW_FREE:        res.ready <= 1'b1;
                    FLOW_COIN:        res.ready <= 1'($urandom_range(0, 1));
                    FLOW_EVERY_THIRD: res.ready <= (rx_cycle % 3 == 0);
                    default:          res.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // stimulus: one phase per register setting, directed items first
    initial
    begin
        int                  pick;
        int                  k;
        int                  spread;
        logic [SAMPLE_W-1:0] red;
        logic [SAMPLE_W-1:0] green;
        logic [SAMPLE_W-1:0] blue;

        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= '0;
        cfg_data         <= '0;
        smp.valid        <= 1'b0;
        smp.sample_red   <= '0;
        smp.sample_green <= '0;
        smp.sample_blue  <= '0;
        squeeze_armed     = 1'b0;
        burst_left        = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            burst_left = 0;

            // settings of this phase; the first runs on the reset values
            next_regs[CFG_SPARE] = rand48();
            case (p)
                0: ;
                1:
                begin
                    // zero window around black, references with ties
                    next_regs[CFG_THRESHOLD] = '0;
                    next_regs[CFG_BASELINE]  = '0;
                    next_regs[CFG_REF0]      = 48'hFFFF_FFFF_FFFF;
                    next_regs[CFG_REF1]      = '0;
                    next_regs[CFG_REF2]      = '0;
                    next_regs[CFG_REF3]      = 48'h0001_0001_0001;
                    next_regs[CFG_REF4]      = 48'h8000_8000_8000;
                end
                2:
                begin
                    // widest window, junk above the threshold width
                    next_regs[CFG_THRESHOLD] = 48'hFFFF_FFFF_FFFF;
                    next_regs[CFG_BASELINE]  = '0;
                    for (k = 0; k < REG_SLOTS; k++)
                        next_regs[int'(CFG_REF0) + k] = rand48();
                end
                3:
                begin
                    // zero window around white, four equal references
                    next_regs[CFG_THRESHOLD] = '0;
                    next_regs[CFG_BASELINE]  = 48'hFFFF_FFFF_FFFF;
                    for (k = 0; k < REG_SLOTS - 1; k++)
                        next_regs[int'(CFG_REF0) + k] = 48'hFFFF_FFFF_FFFF;
                    next_regs[CFG_REF4] = '0;
                end
                default:
                begin
                    case ($urandom_range(0, 3))
                        0: next_regs[CFG_THRESHOLD] = CFG_DATA_W'($urandom_range(0, 40));
                        1: next_regs[CFG_THRESHOLD] = CFG_DATA_W'($urandom_range(0, 65535));
                        2: next_regs[CFG_THRESHOLD] = rand48();
                        default: next_regs[CFG_THRESHOLD] = CFG_DATA_W'($urandom_range(0, 3));
                    endcase
                    if ($urandom_range(0, 1))
                        next_regs[CFG_BASELINE] = rand48();
                    else
                        next_regs[CFG_BASELINE] = {16'($urandom_range(0, 300)),
                                                   16'($urandom_range(0, 300)),
                                                   16'($urandom_range(0, 300))};
                    for (k = 0; k < REG_SLOTS; k++)
                    begin
                        pick = $urandom_range(0, 3);
                        if (pick == 0 && k > 0)
                            // duplicate an earlier reference to force ties
                            next_regs[int'(CFG_REF0) + k] =
                                next_regs[int'(CFG_REF0) + $urandom_range(0, k - 1)];
                        else if (pick == 2)
                            next_regs[int'(CFG_REF0) + k] =
                                {near_value(board.channel(next_regs[CFG_BASELINE], 0), 50),
                                 near_value(board.channel(next_regs[CFG_BASELINE], 1), 50),
                                 near_value(board.channel(next_regs[CFG_BASELINE], 2), 50)};
                        else
                            next_regs[int'(CFG_REF0) + k] = rand48();
                    end
                end
            endcase
            if (p != 0)
                program_registers();

            // directed items
            case (p)
                0:
                begin
                    // window edges of the reset baseline with threshold 25
                    offer(16'd106, 16'd79, 16'd68);
                    offer(16'd131, 16'd79, 16'd68);
                    offer(16'd132, 16'd79, 16'd68);
                    offer(16'd106, 16'd53, 16'd68);
                    offer(16'd106, 16'd79, 16'd43);
                    offer(16'd106, 16'd79, 16'd93);
                    // all references zero: full tie, and the largest distance
                    offer(16'd0, 16'd0, 16'd0);
                    offer(16'hFFFF, 16'hFFFF, 16'hFFFF);
                end
                1:
                begin
                    offer(16'd0, 16'd0, 16'd0);
                    offer(16'd1, 16'd0, 16'd0);
                    offer(16'hFFFF, 16'hFFFF, 16'hFFFF);
                    offer(16'h8000, 16'h8000, 16'h8000);
                    offer(16'd0, 16'd0, 16'd1);
                    offer(16'd1, 16'd1, 16'd1);
                end
                2:
                begin
                    offer(16'hFFFF, 16'hFFFF, 16'hFFFF);
                    offer(16'd0, 16'd0, 16'd0);
                end
                3:
                begin
                    offer(16'hFFFF, 16'hFFFF, 16'hFFFF);
                    offer(16'hFFFE, 16'hFFFF, 16'hFFFF);
                    offer(16'd0, 16'd0, 16'd0);
                end
                default: ;
            endcase

            if (p == 4)
                squeeze_armed = 1'b1;

            // random items: around the window, around a reference, or anywhere
            for (int n = 0; n < RANDOM_ITEMS; n++)
            begin
                pick = $urandom_range(0, 2);
                case (pick)
                    0:
                    begin
                        spread = int'(board.threshold) + 1;
                        red    = near_value(board.channel(board.baseline, 0), spread);
                        green  = near_value(board.channel(board.baseline, 1), spread);
                        blue   = near_value(board.channel(board.baseline, 2), spread);
                    end
                    1:
                    begin
                        k      = $urandom_range(0, NUM_CLASSES - 1);
                        spread = $urandom_range(0, 6);
                        red    = near_value(board.channel(board.refs[k], 0), spread);
                        green  = near_value(board.channel(board.refs[k], 1), spread);
                        blue   = near_value(board.channel(board.refs[k], 2), spread);
                    end
                    default:
                    begin
                        red   = SAMPLE_W'($urandom());
                        green = SAMPLE_W'($urandom());
                        blue  = SAMPLE_W'($urandom());
                    end
                endcase
                offer(red, green, blue);
            end

            // registers change only once the pipeline is empty
            drain();
        end

        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/cnrc_pkg.sv
hw/rtl/cnrc_if.sv
hw/rtl/cnrc_front.sv
hw/rtl/cnrc_dist.sv
hw/rtl/cnrc_min.sv
hw/rtl/color_nearest_reference_classifier.sv
hw/rtl/cnrc_checker.sv
bench/color_nearest_reference_classifier_tb.sv
